// ===== sv/first_fit_segment_allocator_top_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define FFSA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("lbl failed");
`define FFSA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`else
`define FFSA_ASSERT(lbl, clk, rst, prop)
`define FFSA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/ffsa_pkg.sv =====
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned LEN_BITS  = ADDR_BITS + 1;
  localparam int unsigned OWNER_BITS = 8;

  localparam logic [LEN_BITS-1:0] HEAP_MAX = LEN_BITS'(1) << ADDR_BITS;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  base;
    logic [LEN_BITS-1:0]   length;
    logic                  free;
    logic [OWNER_BITS-1:0] owner;
  } seg_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_UP_RD, S_UP_WR, S_SPLIT_LO, S_SPLIT_HI,
    S_NX_RD, S_NX_CHK, S_MERGE, S_DN_RD, S_DN_WR, S_DONE
  } state_t;

endpackage

// ===== sv/first_fit_segment_allocator_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload (lowest bit first)
// s_*       in   action[0], owner_id[8:1], amount[25:9], start_index[41:26]
// m_*       out  status[1:0], start_address[17:2]
// cfg_*     in   heap_size[16:0], written when cfg_we is high
//
// One request at a time. A request walks the segment table one entry at a
// time (address in S_RD, then registered read data in S_CHK). A split moves
// entries up one at a time; a free that merges moves entries down the same
// way. The table has one read and one write port, which sets this pace.
// After reset S_INIT writes the initial segment before the first request
// is taken. A stalled result sits in the output register while the next
// request is accepted; that request finishes only once the register drains.
`include "first_fit_segment_allocator_top_macros.svh"
module first_fit_segment_allocator_top #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // action, owner_id, amount, start_index, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status, start_address, zero pad
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AB = ffsa_pkg::ADDR_BITS;
  localparam int unsigned LB = ffsa_pkg::LEN_BITS;

  ffsa_pkg::state_t state, state_next;

  logic [LB-1:0] heap_size;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [IW-1:0] k;
  logic          dist2;

  logic          req_action;
  logic [7:0]    req_owner;
  logic [LB-1:0] req_amount;
  logic [AB-1:0] req_start;

  ffsa_pkg::seg_t cur, prev, nxt;
  logic           nxt_free;

  logic [1:0]    res_status;
  logic [AB-1:0] res_addr;
  logic [1:0]    out_status;
  logic [AB-1:0] out_addr;
  logic          out_valid;

  logic                 tbl_we;
  logic [IW-1:0]        tbl_waddr;
  ffsa_pkg::seg_t       tbl_wdata;
  logic [IW-1:0]        tbl_raddr;
  ffsa_pkg::seg_t       tbl_rdata;

  logic [LB-1:0] cfg_clamped;
  logic          chk_fit, chk_match, chk_last;
  logic          prev_free, up_more, dn_more, out_free;
  logic [CW:0]   dn_src;

  ffsa_seg_table #(.DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // clamp the heap size into 1 .. 2^ADDR_BITS
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = LB'(1);
    end else if (cfg_wdata > ffsa_pkg::HEAP_MAX) begin
      cfg_clamped = ffsa_pkg::HEAP_MAX;
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  assign chk_fit   = tbl_rdata.free && (tbl_rdata.length >= req_amount);
  assign chk_match = !tbl_rdata.free && (tbl_rdata.owner == req_owner) &&
                     (tbl_rdata.base == req_start);
  assign chk_last  = ((CW'(idx) + CW'(1)) == count);
  assign prev_free = (idx != '0) && prev.free;
  assign up_more   = (k > idx);
  assign dn_src    = (CW + 1)'(k) + (dist2 ? (CW + 1)'(2) : (CW + 1)'(1));
  assign dn_more   = (dn_src < (CW + 1)'(count));
  assign out_free  = !out_valid || m_tready;

  assign s_tready = (state == ffsa_pkg::S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_addr, out_status};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffsa_pkg::S_INIT: state_next = ffsa_pkg::S_IDLE;
      ffsa_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (s_tdata[0] == ffsa_pkg::ACT_ALLOC && s_tdata[25:9] == '0) begin
            state_next = ffsa_pkg::S_DONE;
          end else begin
            state_next = ffsa_pkg::S_RD;
          end
        end
      end
      ffsa_pkg::S_RD: state_next = ffsa_pkg::S_CHK;
      ffsa_pkg::S_CHK: begin
        if (req_action == ffsa_pkg::ACT_ALLOC && chk_fit) begin
          if (tbl_rdata.length == req_amount || count == CW'(MAX_SEGMENTS)) begin
            state_next = ffsa_pkg::S_DONE;
          end else begin
            state_next = ffsa_pkg::S_UP_RD;
          end
        end else if (req_action == ffsa_pkg::ACT_FREE && chk_match) begin
          state_next = chk_last ? ffsa_pkg::S_MERGE : ffsa_pkg::S_NX_RD;
        end else begin
          state_next = chk_last ? ffsa_pkg::S_DONE : ffsa_pkg::S_RD;
        end
      end
      ffsa_pkg::S_UP_RD:    state_next = up_more ? ffsa_pkg::S_UP_WR : ffsa_pkg::S_SPLIT_LO;
      ffsa_pkg::S_UP_WR:    state_next = ffsa_pkg::S_UP_RD;
      ffsa_pkg::S_SPLIT_LO: state_next = ffsa_pkg::S_SPLIT_HI;
      ffsa_pkg::S_SPLIT_HI: state_next = ffsa_pkg::S_DONE;
      ffsa_pkg::S_NX_RD:    state_next = ffsa_pkg::S_NX_CHK;
      ffsa_pkg::S_NX_CHK:   state_next = ffsa_pkg::S_MERGE;
      ffsa_pkg::S_MERGE: begin
        state_next = (prev_free || nxt_free) ? ffsa_pkg::S_DN_RD : ffsa_pkg::S_DONE;
      end
      ffsa_pkg::S_DN_RD:    state_next = dn_more ? ffsa_pkg::S_DN_WR : ffsa_pkg::S_DONE;
      ffsa_pkg::S_DN_WR:    state_next = ffsa_pkg::S_DN_RD;
      ffsa_pkg::S_DONE:     state_next = out_free ? ffsa_pkg::S_IDLE : ffsa_pkg::S_DONE;
      default:              state_next = ffsa_pkg::S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = idx;
    tbl_wdata = tbl_rdata;
    tbl_raddr = idx;
    unique case (state)
      ffsa_pkg::S_INIT: begin
        tbl_we    = 1'b1;
        tbl_waddr = '0;
        tbl_wdata = '{base: '0, length: heap_size, free: 1'b1, owner: '0};
      end
      ffsa_pkg::S_CHK: begin
        // exact fit: take the segment in place
        if (req_action == ffsa_pkg::ACT_ALLOC && chk_fit &&
            tbl_rdata.length == req_amount) begin
          tbl_we    = 1'b1;
          tbl_wdata = '{base: tbl_rdata.base, length: tbl_rdata.length,
                        free: 1'b0, owner: req_owner};
        end
      end
      ffsa_pkg::S_UP_RD: tbl_raddr = k - IW'(1);
      ffsa_pkg::S_UP_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = k;
      end
      ffsa_pkg::S_SPLIT_LO: begin
        tbl_we    = 1'b1;
        tbl_wdata = '{base: cur.base, length: req_amount, free: 1'b0, owner: req_owner};
      end
      ffsa_pkg::S_SPLIT_HI: begin
        tbl_we    = 1'b1;
        tbl_waddr = idx + IW'(1);
        tbl_wdata = '{base: cur.base + req_amount[AB-1:0],
                      length: cur.length - req_amount, free: 1'b1, owner: '0};
      end
      ffsa_pkg::S_NX_RD: tbl_raddr = idx + IW'(1);
      ffsa_pkg::S_MERGE: begin
        tbl_we = 1'b1;
        if (prev_free) begin
          tbl_waddr = idx - IW'(1);
          tbl_wdata = '{base: prev.base,
                        length: prev.length + cur.length + (nxt_free ? nxt.length : '0),
                        free: 1'b1, owner: '0};
        end else begin
          tbl_wdata = '{base: cur.base,
                        length: cur.length + (nxt_free ? nxt.length : '0),
                        free: 1'b1, owner: '0};
        end
      end
      ffsa_pkg::S_DN_RD: tbl_raddr = dn_src[IW-1:0];
      ffsa_pkg::S_DN_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = k;
      end
      default: ;
    endcase
    // a heap size write rebuilds the single free segment
    if (cfg_we) begin
      tbl_we    = 1'b1;
      tbl_waddr = '0;
      tbl_wdata = '{base: '0, length: cfg_clamped, free: 1'b1, owner: '0};
    end
  end

  // control and data registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffsa_pkg::S_INIT;
      heap_size <= ffsa_pkg::HEAP_MAX;
      count     <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ffsa_pkg::S_INIT: count <= CW'(1);
        ffsa_pkg::S_IDLE: begin
          if (s_tvalid) begin
            req_action <= s_tdata[0];
            req_owner  <= s_tdata[8:1];
            req_amount <= s_tdata[25:9];
            req_start  <= s_tdata[41:26];
            idx        <= '0;
            res_status <= ffsa_pkg::ST_MISS;
            res_addr   <= '0;
          end
        end
        ffsa_pkg::S_CHK: begin
          cur <= tbl_rdata;
          if (req_action == ffsa_pkg::ACT_ALLOC && chk_fit) begin
            if (tbl_rdata.length == req_amount) begin
              res_status <= ffsa_pkg::ST_OK;
              res_addr   <= tbl_rdata.base;
            end else if (count == CW'(MAX_SEGMENTS)) begin
              res_status <= ffsa_pkg::ST_FULL;
            end else begin
              k <= count[IW-1:0];
            end
          end else if (req_action == ffsa_pkg::ACT_FREE && chk_match) begin
            nxt_free <= 1'b0;
          end else begin
            prev <= tbl_rdata;
            if (!chk_last) begin
              idx <= idx + IW'(1);
            end
          end
        end
        ffsa_pkg::S_UP_WR: k <= k - IW'(1);
        ffsa_pkg::S_SPLIT_HI: begin
          count      <= count + CW'(1);
          res_status <= ffsa_pkg::ST_OK;
          res_addr   <= cur.base;
        end
        ffsa_pkg::S_NX_CHK: begin
          nxt      <= tbl_rdata;
          nxt_free <= tbl_rdata.free;
        end
        ffsa_pkg::S_MERGE: begin
          res_status <= ffsa_pkg::ST_OK;
          dist2      <= prev_free && nxt_free;
          k          <= prev_free ? idx : idx + IW'(1);
        end
        ffsa_pkg::S_DN_RD: begin
          if (!dn_more) begin
            count <= count - (dist2 ? CW'(2) : CW'(1));
          end
        end
        ffsa_pkg::S_DN_WR: k <= k + IW'(1);
        ffsa_pkg::S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_addr   <= res_addr;
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        heap_size <= cfg_clamped;
        count     <= CW'(1);
      end
    end
  end

  `FFSA_ASSERT(a_count_range, clk, rst, (count != '0) && (count <= CW'(MAX_SEGMENTS)))
  `FFSA_ASSERT(a_cfg_one_seg, clk, rst, cfg_we |=> (count == CW'(1)))
  `FFSA_ASSERT(a_status_code, clk, rst, m_tvalid |-> (m_tdata[1:0] != 2'd3))
  `FFSA_ASSERT(a_addr_zero_on_fail, clk, rst, (m_tvalid && m_tdata[1:0] != ffsa_pkg::ST_OK) |-> (m_tdata[17:2] == '0))
  `FFSA_ASSERT_ALWAYS(a_reset_idle_out, clk, rst |=> !m_tvalid)

endmodule

// ===== sv/ffsa_seg_table.sv =====
`timescale 1ns / 1ps
module ffsa_seg_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ffsa_pkg::seg_t           wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ffsa_pkg::seg_t           rdata
);

  ffsa_pkg::seg_t mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int unsigned NSEG       = 64;
  localparam int unsigned CYCLE_CAP  = 4000000;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] addr;
  } alloc_reply_t;

  // Mirror of the segment table: predicts the reply to each accepted word
  // and holds the replies still owed by the block.
  class heap_scoreboard;
    logic [16:0]  heap_words;
    logic [15:0]  seg_base [NSEG];
    logic [16:0]  seg_len [NSEG];
    bit           seg_free [NSEG];
    logic [7:0]   seg_owner [NSEG];
    int           seg_cnt;
    alloc_reply_t owed [$];
    int           errors;

    function void set_heap(logic [16:0] v);
      heap_words = (v == '0) ? 17'd1 :
                   (v > ffsa_pkg::HEAP_MAX) ? ffsa_pkg::HEAP_MAX : v;
      for (int k = 0; k < NSEG; k++) begin
        seg_base[k] = '0; seg_len[k] = '0; seg_free[k] = 1'b0; seg_owner[k] = '0;
      end
      seg_len[0] = heap_words;
      seg_free[0] = 1'b1;
      seg_cnt = 1;
    endfunction

    function void drop_entry(int pos);
      for (int k = pos; k + 1 < seg_cnt; k++) begin
        seg_base[k] = seg_base[k+1]; seg_len[k] = seg_len[k+1];
        seg_free[k] = seg_free[k+1]; seg_owner[k] = seg_owner[k+1];
      end
      seg_cnt--;
    endfunction

    function void note_request(logic act, logic [7:0] own, logic [16:0] amt,
                               logic [15:0] st);
      alloc_reply_t r;
      int i;
      logic [15:0] b;
      r.status = ffsa_pkg::ST_MISS;
      r.addr = '0;
      if (act == ffsa_pkg::ACT_ALLOC) begin
        if (amt != '0) begin
          for (i = 0; i < seg_cnt; i++)
            if (seg_free[i] && seg_len[i] >= amt) break;
          if (i < seg_cnt) begin
            b = seg_base[i];
            if (seg_len[i] == amt) begin
              seg_free[i] = 1'b0; seg_owner[i] = own;
              r.status = ffsa_pkg::ST_OK; r.addr = b;
            end else if (seg_cnt >= NSEG) begin
              r.status = ffsa_pkg::ST_FULL;
            end else begin
              for (int k = seg_cnt; k > i; k--) begin
                seg_base[k] = seg_base[k-1]; seg_len[k] = seg_len[k-1];
                seg_free[k] = seg_free[k-1]; seg_owner[k] = seg_owner[k-1];
              end
              seg_cnt++;
              seg_len[i] = amt; seg_free[i] = 1'b0; seg_owner[i] = own;
              seg_base[i+1] = b + amt[15:0];
              seg_len[i+1] = seg_len[i+1] - amt;
              r.status = ffsa_pkg::ST_OK; r.addr = b;
            end
          end
        end
      end else begin
        for (i = 0; i < seg_cnt; i++)
          if (!seg_free[i] && seg_owner[i] == own && seg_base[i] == st) break;
        if (i < seg_cnt) begin
          seg_free[i] = 1'b1; seg_owner[i] = '0;
          if (i > 0 && seg_free[i-1]) begin
            seg_len[i-1] = seg_len[i-1] + seg_len[i];
            drop_entry(i);
            i--;
          end
          if (i + 1 < seg_cnt && seg_free[i+1]) begin
            seg_len[i] = seg_len[i] + seg_len[i+1];
            drop_entry(i + 1);
          end
          r.status = ffsa_pkg::ST_OK;
        end
      end
      owed.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [15:0] a);
      alloc_reply_t r;
      if (owed.size() == 0) begin
        report($sformatf("unexpected reply status=%0d addr=%0d", st, a));
      end else begin
        r = owed.pop_front();
        if (st !== r.status)
          report($sformatf("status %0d, want %0d", st, r.status));
        if (a !== r.addr)
          report($sformatf("start_address %0d, want %0d", a, r.addr));
      end
    endtask
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready, cfg_we;
  logic [47:0] s_tdata;   // action, owner_id, amount, start_index, zero pad
  logic [23:0] m_tdata;   // status, start_address, zero pad
  logic [16:0] cfg_wdata;

  heap_scoreboard sb;
  int  idle_mode;          // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
  bit  hold_req;
  int  hold_left;
  int unsigned cycles;

  first_fit_segment_allocator_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("first_fit_segment_allocator_top test failed");
      $finish;
    end
  end

  // Receiver: stall at random per mode, or hold off for a long stretch
  // when asked so the input backs up. Check each word taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata[1:0], m_tdata[17:2]);
      if (hold_req && hold_left == 0) begin
        hold_left <= HOLD_LEN;
        m_tready <= 1'b0;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        hold_left <= 0;
        case (idle_mode)
          2: m_tready <= ($urandom_range(99) >= 51);
          3: m_tready <= ($urandom_range(99) >= 21);
          default: m_tready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one word, with random gaps first; note it once it is taken.
  task automatic send_req(logic act, logic [7:0] own, logic [16:0] amt,
                          logic [15:0] st);
    int pct;
    pct = (idle_mode == 1) ? 51 : (idle_mode == 3) ? 21 : 0;
    while ($urandom_range(99) < pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, st, amt, own, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(act, own, amt, st);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_heap(logic [16:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_heap(v);
    repeat (4) @(posedge clk);
  endtask

  // Mostly small allocations and frees of live segments, some noise.
  task automatic random_req();
    int pick, n, j;
    logic [16:0] amt;
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(9) == 0) amt = 17'($urandom_range(17'h1FFFF));
      else amt = 17'($urandom_range(1, (sb.heap_words > 32) ? sb.heap_words / 24 : 2));
      send_req(ffsa_pkg::ACT_ALLOC, 8'($urandom_range(255)), amt,
               16'($urandom_range(16'hFFFF)));
    end else if (pick < 90) begin
      n = 0;
      for (int k = 0; k < sb.seg_cnt; k++) if (!sb.seg_free[k]) n++;
      if (n == 0) begin
        send_req(ffsa_pkg::ACT_ALLOC, 8'($urandom_range(255)), 17'd1, 16'd0);
      end else begin
        j = $urandom_range(n - 1);
        for (int k = 0; k < sb.seg_cnt; k++)
          if (!sb.seg_free[k]) begin
            if (j == 0)
              send_req(ffsa_pkg::ACT_FREE, sb.seg_owner[k],
                       17'($urandom_range(17'h1FFFF)), sb.seg_base[k]);
            j--;
          end
      end
    end else begin
      send_req(ffsa_pkg::ACT_FREE, 8'($urandom_range(255)),
               17'($urandom_range(17'h1FFFF)), 16'($urandom_range(16'hFFFF)));
    end
  endtask

  initial begin
    logic [16:0] heaps [6];
    heaps = '{17'd1000, 17'd0, 17'd300, 17'h1FFFF, 17'd1, 17'd65536};
    clk = 0; rst = 1; cycles = 0;
    s_tvalid = 0; s_tdata = 0; m_tready = 0; cfg_we = 0; cfg_wdata = 0;
    idle_mode = 0; hold_req = 0; hold_left = 0;
    sb = new();
    sb.set_heap(ffsa_pkg::HEAP_MAX);
    sb.errors = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Directed: zero amount, exact fit of the whole heap, no fit,
    // wrong owner, frees that merge above and on both sides.
    send_req(ffsa_pkg::ACT_ALLOC, 8'd7, 17'd0, 16'hFFFF);
    send_req(ffsa_pkg::ACT_ALLOC, 8'd255, 17'h10000, 16'd0);
    send_req(ffsa_pkg::ACT_ALLOC, 8'd1, 17'd1, 16'd0);
    send_req(ffsa_pkg::ACT_FREE, 8'd254, 17'h1FFFF, 16'd0);
    send_req(ffsa_pkg::ACT_FREE, 8'd255, 17'd0, 16'd0);
    send_req(ffsa_pkg::ACT_ALLOC, 8'd0, 17'd1, 16'd0);
    send_req(ffsa_pkg::ACT_ALLOC, 8'd1, 17'd2, 16'd0);
    send_req(ffsa_pkg::ACT_ALLOC, 8'd2, 17'd3, 16'd0);
    send_req(ffsa_pkg::ACT_ALLOC, 8'hAA, 17'h0FFFF, 16'd0);
    send_req(ffsa_pkg::ACT_FREE, 8'd1, 17'd0, 16'd1);
    send_req(ffsa_pkg::ACT_FREE, 8'd1, 17'd0, 16'd1);
    send_req(ffsa_pkg::ACT_FREE, 8'd0, 17'd0, 16'd0);
    send_req(ffsa_pkg::ACT_FREE, 8'd2, 17'd0, 16'd3);
    send_req(ffsa_pkg::ACT_FREE, 8'h55, 17'd0, 16'hFFFF);
    drain();

    // Fill the table: a split with all entries in use is refused,
    // an exact fit still goes through.
    write_heap(17'd100);
    for (int k = 0; k < 63; k++) send_req(ffsa_pkg::ACT_ALLOC, k[7:0], 17'd1, 16'd0);
    send_req(ffsa_pkg::ACT_ALLOC, 8'd9, 17'd1, 16'd0);
    send_req(ffsa_pkg::ACT_ALLOC, 8'd9, 17'd37, 16'd0);
    drain();

    // Random phases, each under a heap size from the list and idle_mode p % 4.
    for (int p = 0; p < 6; p++) begin
      write_heap(heaps[p]);
      idle_mode = p % 4;
      for (int k = 0; k < 120; k++) begin
        if (p == 2 && k == 10) hold_req = 1'b1;
        if (p == 2 && k == 14) hold_req = 1'b0;
        random_req();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("first_fit_segment_allocator_top test passed");
    end else begin
      $display("first_fit_segment_allocator_top test failed");
    end
    $finish;
  end
endmodule
